// ===== rtl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the find-and-replace stream
// Holds the job record passed from the front end to the output sequencer,
// the register indexes of the configuration port, and the job queue sizes.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int CHAR_W          = 8;
    localparam int PACK_W          = MAX_PATTERN * CHAR_W;
    localparam int LEN_W           = 4;
    localparam int FILL_W          = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_index;

    // A job: up to eight bytes to emit, lowest byte first. A job with no
    // bytes is a bare end marker.
    typedef struct packed {
        logic [PACK_W-1:0] bytes;
        logic [LEN_W-1:0]  count;
        logic              last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/srs_front.sv =====
// ----------------------------------------------------------------------------
// srs_front: input window and match classification
// Holds the configuration and the match window, accepts input beats and turns
// each one into at most one job for the output sequencer.
// ----------------------------------------------------------------------------
module srs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [srs_pkg::CHAR_W-1:0]     i_in_char,
    input  logic                           i_in_last,
    input  srs_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output srs_pkg::t_job                  o_job
);
    import srs_pkg::*;

    logic [PACK_W-1:0]  r_pattern;
    logic [LEN_W-1:0]   r_plen_raw;
    logic [PACK_W-1:0]  r_repl;
    logic [LEN_W-1:0]   r_rlen_raw;
    logic [PACK_W-1:0]  r_win;
    logic [FILL_W-1:0]  r_fill;

    logic [PACK_W-1:0]  n_win;
    logic [FILL_W-1:0]  n_fill;
    logic [LEN_W-1:0]   w_plen;
    logic [LEN_W-1:0]   w_rlen;
    logic [PACK_W-1:0]  w_win;
    logic [LEN_W-1:0]   w_fill1;
    logic               w_full;
    logic               w_match;
    logic               w_accept;

    assign w_plen = (r_plen_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_plen_raw;
    assign w_rlen = (r_rlen_raw > LEN_W'(MAX_REPLACEMENT)) ?
                    LEN_W'(MAX_REPLACEMENT) : r_rlen_raw;

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;
    assign w_fill1  = {1'b0, r_fill} + LEN_W'(1);
    assign w_full   = (w_fill1 == w_plen);

    always_comb begin
        w_win   = r_win;
        w_match = w_full;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (FILL_W'(k) == r_fill) begin
                w_win[k*CHAR_W +: CHAR_W] = i_in_char;
            end
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((LEN_W'(k) < w_plen) &&
                (w_win[k*CHAR_W +: CHAR_W] != r_pattern[k*CHAR_W +: CHAR_W])) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_job  = '{bytes: w_win, count: w_fill1, last: i_in_last};
        n_win  = w_win;
        n_fill = r_fill;
        if (w_accept) begin
            if (w_plen == '0) begin
                o_push = 1'b1;
                o_job  = '{bytes: {{(PACK_W-CHAR_W){1'b0}}, i_in_char},
                           count: LEN_W'(1), last: i_in_last};
                n_fill = '0;
            end else if (w_match) begin
                o_push = (w_rlen != '0) || i_in_last;
                o_job  = '{bytes: r_repl, count: w_rlen, last: i_in_last};
                n_fill = '0;
            end else if (w_full && !i_in_last) begin
                o_push = 1'b1;
                o_job  = '{bytes: w_win, count: LEN_W'(1), last: 1'b0};
                n_win  = w_win >> CHAR_W;
                n_fill = FILL_W'(w_plen - LEN_W'(1));
            end else if (i_in_last) begin
                o_push = 1'b1;
                n_fill = '0;
            end else begin
                n_fill = FILL_W'(w_fill1);
            end
        end
        if (i_cfg_we && (i_cfg_index == CFG_PATTERN_LENGTH)) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_plen_raw <= '0;
            r_repl     <= '0;
            r_rlen_raw <= '0;
            r_fill     <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_PATTERN_BYTES: begin
                        r_pattern <= i_cfg_data;
                    end
                    CFG_PATTERN_LENGTH: begin
                        r_plen_raw <= i_cfg_data[LEN_W-1:0];
                    end
                    CFG_REPLACEMENT_BYTES: begin
                        r_repl <= i_cfg_data;
                    end
                    CFG_REPLACEMENT_LENGTH: begin
                        r_rlen_raw <= i_cfg_data[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_plen != '0) |-> ({1'b0, r_fill} < w_plen))
        else $error("window fill reached the pattern length");

endmodule

// ===== rtl/srs_queue.sv =====
// ----------------------------------------------------------------------------
// srs_queue: job queue between front end and output sequencer
// A small first-in first-out buffer of job records; the head is visible
// combinationally and leaves on pop.
// ----------------------------------------------------------------------------
module srs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srs_pkg::t_job    i_job,
    input  logic             i_pop,
    output srs_pkg::t_job    o_head,
    output srs_pkg::t_q_stat o_stat
);
    import srs_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into a full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from an empty job queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");

endmodule

// ===== rtl/srs_back.sv =====
// ----------------------------------------------------------------------------
// srs_back: output sequencer
// Walks the job at the queue head one byte per beat into the output
// register, marks the final beat of a text and emits bare end markers.
// ----------------------------------------------------------------------------
module srs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  srs_pkg::t_job              i_head,
    input  srs_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [srs_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_char_present,
    output logic                       o_out_last
);
    import srs_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_present;
    logic              r_last;
    logic [FILL_W-1:0] r_pos;

    logic              w_load;
    logic              w_end;
    logic [CHAR_W-1:0] w_char;

    assign o_valid        = r_valid;
    assign o_out_char     = r_char;
    assign o_char_present = r_present;
    assign o_out_last     = r_last;

    assign w_load = !r_valid || !i_stall;
    assign w_end  = (i_head.count == '0) || ({1'b0, r_pos} == i_head.count - LEN_W'(1));
    assign w_char = i_head.bytes[{r_pos, 3'b000} +: CHAR_W];
    assign o_pop  = w_load && !i_q_stat.empty && w_end;

    always_ff @(posedge i_clk) begin
        if (w_load && !i_q_stat.empty) begin
            r_char    <= (i_head.count == '0) ? '0 : w_char;
            r_present <= (i_head.count != '0);
            r_last    <= i_head.last && w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (w_load) begin
            r_valid <= !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                r_pos <= w_end ? '0 : r_pos + FILL_W'(1);
            end
        end
    end

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_present) |-> r_last)
        else $error("bare end marker without the last flag");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.empty |-> (r_pos == '0))
        else $error("byte position left over with no job pending");

endmodule

// ===== rtl/substring_replace_stream.sv =====
// ----------------------------------------------------------------------------
// substring_replace_stream: streaming find-and-replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement string.
// ----------------------------------------------------------------------------
// Usage:
// Text enters one byte per beat on i_valid / o_stall with i_in_last on the
// final byte. Results leave on o_valid / i_stall, one byte per beat, with
// o_char_present low for a bare end marker and o_out_last on the final beat
// of a text. Configuration is written through i_cfg_we / i_cfg_index /
// i_cfg_data while the block is idle; writing the pattern length empties the
// match window.
// Accepted beats pass as jobs through the queue to the output register.
// The front end takes one byte per cycle while o_stall is low and the output
// sequencer emits one byte per cycle while i_stall is low, so plain text
// flows at one byte per cycle. A match or a flush at end of text emits up to
// eight bytes from one input beat; the four-entry job queue absorbs this, and
// o_stall rises only when it is full. When the receiver stalls, the output
// beat holds and the queue fills. Synchronous reset clears the configuration
// registers and the window fill to zero, empties the queue and drops o_valid.
// ----------------------------------------------------------------------------
module substring_replace_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [srs_pkg::CHAR_W-1:0]     i_in_char,
    input  logic                           i_in_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [srs_pkg::CHAR_W-1:0]     o_out_char,
    output logic                           o_char_present,
    output logic                           o_out_last
);
    import srs_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_job    w_job;
    t_job    w_head;
    t_q_stat w_q_stat;

    srs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    srs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    srs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_char_present (o_char_present),
        .o_out_last     (o_out_last)
    );

endmodule
